/* sv/pli_pkg.sv */
// Shared types and codes for the piecewise linear interpolator.
// Depends on nothing; imported by every module of the block.
package pli_pkg;
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FEW_ROWS  = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO  = 2'd2;
   localparam logic       REQ_WRITE        = 1'b0;
   localparam logic       REQ_QUERY        = 1'b1;
   localparam logic       CSR_ROW_COUNT    = 1'b0;
   localparam logic       CSR_SLOPE_MODE   = 1'b1;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;
endpackage

/* sv/pli_div.sv */
// Iterative signed 32-bit divider, one quotient bit a cycle, truncating to zero.
// Depends on pli_pkg.
module pli_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pli_pkg::div_req_type div_req,
   output pli_pkg::div_rsp_type div_rsp
);
   import pli_pkg::*;

   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dmag_ff, dmag_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] nmag;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      nmag    = div_req.num[31] ? (32'd0 - div_req.num) : div_req.num;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dmag_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = '0;
         quo_in  = nmag;
         dmag_in = div_req.den[31] ? (32'd0 - div_req.den) : div_req.den;
         neg_in  = div_req.num[31] ^ div_req.den[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = neg_ff ? (32'd0 - quo_ff) : quo_ff;
endmodule

/* sv/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator: table memories, scan sequencer.
// Depends on pli_pkg and pli_div.
//
//   channel  direction  ports                       moves
//   req      in         req_valid/req_ready         one write or query item
//   rsp      out        rsp_valid/rsp_ready         one result item per query
//   csr      in         csr_valid/csr_ready         one register write
//
// A write item is stored in the memories as it is accepted. A query reads the table
// one row a cycle from the synchronous memories, then the states S_RDLO, S_RDHI and
// S_GOTHI read the two chosen rows, then one multiply and one add follow; in divide
// mode the bit-serial divider runs before the multiply. A query with too few rows, or
// with zero dx in divide mode, goes straight to its result. Reset clears control state
// only; the memories hold nothing defined until written. A result waits in its output
// register while rsp_ready is low, and the next item is not taken until it leaves.
module piecewise_linear_interpolator #(
   parameter int MAX_ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [3:0]  req_row_index,
   input  logic [31:0] req_row_x,
   input  logic [31:0] req_row_y,
   input  logic [31:0] req_row_slope,
   input  logic [31:0] req_query_x,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_y_value,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   import pli_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = $clog2(MAX_ROWS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_RDLO, S_RDHI, S_GOTHI, S_DIV, S_MUL, S_ADD, S_OUT
   } state_type;

   // Breakpoint storage: three synchronous memories sharing one address.
   logic [31:0] mem_x [MAX_ROWS];
   logic [31:0] mem_y [MAX_ROWS];
   logic [31:0] mem_s [MAX_ROWS];
   logic [31:0] rd_x_ff, rd_y_ff, rd_s_ff;

   state_type   state_ff;
   logic [4:0]  row_count_ff;
   logic        slope_mode_ff;
   logic [CW-1:0] n_ff, e_ff;     // clamped row count, scan position
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic [31:0] qx_ff, x0_ff, y0_ff, slope_ff, prod_ff;
   logic [31:0] yv_ff;
   logic [1:0]  st_ff;
   logic        rsp_valid_ff, first_ff;
   logic [CW-1:0] lo_ff;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [CW-1:0] n_clamp;
   logic        wr_en;

   pli_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_y_value = yv_ff;
   assign rsp_status = st_ff;
   assign n_clamp = (32'(row_count_ff) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(row_count_ff);
   assign wr_en = req_valid && req_ready && (req_type == REQ_WRITE)
                  && (32'(req_row_index) < MAX_ROWS);
   assign waddr = AW'(req_row_index);

   // The read address follows the sequencer: scan position, then lower and upper rows.
   always_comb begin
      case (state_ff)
         S_SCAN:  raddr = e_ff[AW-1:0];
         S_RDLO:  raddr = lo_ff[AW-1:0];
         S_RDHI:  raddr = AW'(lo_ff + CW'(1));
         default: raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[waddr] <= req_row_x;
         mem_y[waddr] <= req_row_y;
         mem_s[waddr] <= req_row_slope;
      end
      rd_x_ff <= mem_x[raddr];
      rd_y_ff <= mem_y[raddr];
      rd_s_ff <= mem_s[raddr];
   end

   always_comb begin
      div_req.start = (state_ff == S_GOTHI) && !slope_mode_ff && (rd_x_ff != x0_ff);
      div_req.num   = rd_y_ff - y0_ff;
      div_req.den   = rd_x_ff - x0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_count_ff  <= '0;
         slope_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROW_COUNT) row_count_ff <= csr_data;
            else                            slope_mode_ff <= csr_data[0];
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_type == REQ_QUERY) begin
                  qx_ff <= req_query_x;
                  n_ff  <= n_clamp;
                  e_ff  <= '0;
                  first_ff <= 1'b1;
                  if (n_clamp < CW'(2)) begin
                     yv_ff <= '0;
                     st_ff <= STATUS_FEW_ROWS;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            // One row address a cycle; the data of the previous address is tested.
            S_SCAN: begin
               first_ff <= 1'b0;
               if (!first_ff && ($signed(rd_x_ff) > $signed(qx_ff))) begin
                  lo_ff <= (e_ff == CW'(1)) ? '0 : e_ff - CW'(2);
                  state_ff <= S_RDLO;
               end else if (!first_ff && e_ff == n_ff) begin
                  lo_ff <= n_ff - CW'(2);
                  state_ff <= S_RDLO;
               end else begin
                  e_ff <= e_ff + CW'(1);
               end
            end
            S_RDLO: state_ff <= S_RDHI;
            S_RDHI: begin
               x0_ff <= rd_x_ff;
               y0_ff <= rd_y_ff;
               slope_ff <= rd_s_ff;
               state_ff <= S_GOTHI;
            end
            S_GOTHI: begin
               if (slope_mode_ff) begin
                  state_ff <= S_MUL;
               end else if (rd_x_ff == x0_ff) begin
                  yv_ff <= y0_ff;
                  st_ff <= STATUS_DIV_ZERO;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  slope_ff <= div_rsp.quot;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= 32'(slope_ff * (qx_ff - x0_ff));
               state_ff <= S_ADD;
            end
            S_ADD: begin
               yv_ff <= prod_ff + y0_ff;
               st_ff <= STATUS_OK;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* tb/tb_piecewise_linear_interpolator.sv */
// Self-checking testbench for the piecewise linear interpolator.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL.
module tb_piecewise_linear_interpolator;
   import pli_pkg::*;

   localparam int NUM_ROWS   = 16;
   localparam int SETTLE     = 80;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic        kind;
      logic [3:0]  row;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] bslope;
      logic [31:0] qx;
   } lut_item_type;

   typedef struct {
      logic [31:0] y_value;
      logic [1:0]  status;
   } lut_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_WRITE;
   logic [3:0]  req_row_index = '0;
   logic [31:0] req_row_x = '0;
   logic [31:0] req_row_y = '0;
   logic [31:0] req_row_slope = '0;
   logic [31:0] req_query_x = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_y_value;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_ROW_COUNT;
   logic [4:0]  csr_data = '0;

   // The testbench's own view of the table and registers.
   logic [31:0] tbl_x [NUM_ROWS];
   logic [31:0] tbl_y [NUM_ROWS];
   logic [31:0] tbl_slope [NUM_ROWS];
   logic [4:0]  shadow_rows = '0;
   logic        shadow_slope_mode = 1'b0;

   lut_item_type   pending_items [$];
   lut_result_type expected_y [$];
   lut_item_type   held_item;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int few_rows_seen = 0;
   int div_zero_seen = 0;

   piecewise_linear_interpolator u_dut (.*);

   always #5 clock = ~clock;

   // Signed division truncating toward zero; the most negative value divided by
   // minus one wraps back to itself.
   function automatic logic [31:0] div_toward_zero(logic [31:0] num, logic [31:0] den);
      logic [31:0] nmag, dmag, q;
      nmag = num[31] ? -num : num;
      dmag = den[31] ? -den : den;
      q = nmag / dmag;
      return (num[31] != den[31]) ? -q : q;
   endfunction

   // Applies one accepted item to the shadow table and, for a query, works out
   // the expected result.
   task automatic interpolate(input lut_item_type it);
      lut_result_type r;
      int          n, e, lo, hi;
      logic [31:0] slope, dx, dy;
      if (it.kind == REQ_WRITE) begin
         tbl_x[it.row] = it.bx;
         tbl_y[it.row] = it.by;
         tbl_slope[it.row] = it.bslope;
         return;
      end
      n = (shadow_rows > NUM_ROWS) ? NUM_ROWS : shadow_rows;
      if (n < 2) begin
         r.y_value = '0;
         r.status = STATUS_FEW_ROWS;
         expected_y.push_back(r);
         return;
      end
      for (e = 0; e < n; e++)
         if ($signed(tbl_x[e]) > $signed(it.qx)) break;
      if (e == 0) begin
         lo = 0; hi = 1;
      end else if (e >= n) begin
         lo = n - 2; hi = n - 1;
      end else begin
         lo = e - 1; hi = e;
      end
      r.status = STATUS_OK;
      if (shadow_slope_mode) begin
         slope = tbl_slope[lo];
      end else begin
         dx = tbl_x[hi] - tbl_x[lo];
         dy = tbl_y[hi] - tbl_y[lo];
         if (dx == 0) begin
            r.y_value = tbl_y[lo];
            r.status = STATUS_DIV_ZERO;
            expected_y.push_back(r);
            return;
         end
         slope = div_toward_zero(dy, dx);
      end
      r.y_value = slope * (it.qx - tbl_x[lo]) + tbl_y[lo];
      expected_y.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want, results_seen);
   endtask

   // Driver: presents the next pending item, honouring the sender idle rate.
   // The valid is decided once per edge so it never gets two assignments.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            interpolate(held_item);
            items_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            held_item = pending_items.pop_front();
            req_type <= held_item.kind;
            req_row_index <= held_item.row;
            req_row_x <= held_item.bx;
            req_row_y <= held_item.by;
            req_row_slope <= held_item.bslope;
            req_query_x <= held_item.qx;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: checks each result against the oldest expectation and
   // randomises the back-pressure.
   always @(posedge clock) begin
      lut_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_y.size() == 0) begin
               report_mismatch("unexpected result", rsp_y_value, 32'h0);
            end else begin
               want = expected_y.pop_front();
               if (rsp_y_value !== want.y_value)
                  report_mismatch("y_value", rsp_y_value, want.y_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
               if (want.status == STATUS_FEW_ROWS) few_rows_seen++;
               if (want.status == STATUS_DIV_ZERO) div_zero_seen++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_y.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Waits until every item has gone in and every result has come back, then
   // lets a settling time pass. The test is made on the falling edge so that
   // the driver's updates have all landed.
   task automatic drain();
      @(negedge clock);
      while (pending_items.size() > 0 || req_valid || expected_y.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [4:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROW_COUNT) shadow_rows = value;
      else shadow_slope_mode = value[0];
   endtask

   task automatic queue_row(input int row, input logic [31:0] bx, input logic [31:0] by,
                            input logic [31:0] bslope);
      lut_item_type it;
      it.kind = REQ_WRITE;
      it.row = row[3:0];
      it.bx = bx;
      it.by = by;
      it.bslope = bslope;
      it.qx = $urandom;
      pending_items.push_back(it);
   endtask

   task automatic queue_query(input logic [31:0] qx);
      lut_item_type it;
      it.kind = REQ_QUERY;
      it.row = 4'($urandom);
      it.bx = $urandom;
      it.by = $urandom;
      it.bslope = $urandom;
      it.qx = qx;
      pending_items.push_back(it);
   endtask

   // Loads all sixteen rows with a sorted set of x values. Narrow spreads give
   // repeated x and so zero dx; wide spreads exercise wrapping arithmetic.
   task automatic queue_sorted_table();
      int          spread;
      logic [31:0] xs [$];
      spread = $urandom_range(3);
      for (int i = 0; i < NUM_ROWS; i++) begin
         case (spread)
            0: xs.push_back($urandom_range(20) - 10);
            1: xs.push_back($urandom_range(2000) - 1000);
            default: xs.push_back($urandom);
         endcase
      end
      xs.sort() with ($signed(item));
      for (int i = 0; i < NUM_ROWS; i++)
         queue_row(i, xs[i], (spread == 1) ? $urandom_range(4000) - 2000 : $urandom,
                   ($urandom_range(1)) ? $urandom_range(20) - 10 : $urandom);
   endtask

   // Picks a query x near a breakpoint, at an extreme, or anywhere.
   function automatic logic [31:0] pick_query_x();
      int k;
      k = $urandom_range(NUM_ROWS - 1);
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return tbl_x[k] + $urandom_range(4) - 2;
      endcase
   endfunction

   initial begin
      int rows_setting;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Every row is written before any query reads the table.
      queue_row(0, 32'd1, 32'd0, 32'h7fff_ffff);
      queue_row(1, 32'd0, 32'h8000_0000, 32'h8000_0000);
      for (int i = 2; i < NUM_ROWS; i++)
         queue_row(i, 32'(i * 100), 32'(i * 7), 32'hffff_ffff);
      queue_query(32'd0);
      drain();
      // Too few rows, with the register at zero and at one.
      queue_query(32'h7fff_ffff);
      drain();
      write_register(CSR_ROW_COUNT, 5'd1);
      queue_query(32'h8000_0000);
      drain();
      // Two rows in reverse order: the most negative dy over a dx of minus one.
      write_register(CSR_ROW_COUNT, 5'd2);
      queue_query(32'd0);
      queue_query(32'h8000_0000);
      queue_query(32'h7fff_ffff);
      drain();
      write_register(CSR_SLOPE_MODE, 5'd1);
      queue_query(32'd5);
      drain();
      // A count beyond the table size is clamped to the full table.
      write_register(CSR_ROW_COUNT, 5'd31);
      queue_row(5, 32'd400, 32'd3, 32'd2);
      queue_query(32'd450);
      queue_query(32'd401);
      drain();
      write_register(CSR_SLOPE_MODE, 5'd0);
      queue_query(32'd399);
      queue_query(32'd1600);
      drain();

      // Random part: phases cycle through the idling patterns and settings.
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
         endcase
         case (phase % 6)
            0: rows_setting = 16;
            1: rows_setting = 2;
            2: rows_setting = 0;
            3: rows_setting = 31;
            default: rows_setting = $urandom_range(3, 15);
         endcase
         write_register(CSR_ROW_COUNT, rows_setting[4:0]);
         write_register(CSR_SLOPE_MODE, {4'd0, phase[0]});
         queue_sorted_table();
         drain();
         for (int i = 0; i < 125; i++) begin
            if ($urandom_range(19) == 0) begin
               // An occasional stray write, sometimes breaking the ordering.
               queue_row($urandom_range(NUM_ROWS - 1), $urandom, $urandom, $urandom);
               // The shadow table only changes on acceptance, so wait for it.
               @(negedge clock);
               while (pending_items.size() > 0 || req_valid) @(negedge clock);
            end else begin
               queue_query(pick_query_x());
            end
         end
         drain();
      end

      $display("Sent %0d items and checked %0d results across 12 random phases;",
               items_sent, results_seen);
      $display("%0d too-few-rows and %0d zero-dx results were seen.",
               few_rows_seen, div_zero_seen);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
